// ===== design/cot_pkg.sv =====
// Shared types and constants for the center-out tile order unit.
// No dependencies; compiled first.
package cot_pkg;

  localparam int COORD_BITS = 16;
  localparam int LEVEL_BITS = 5;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [1:0]            ext_t;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  localparam ext_t EXT_EVEN = 2'd1;
  localparam ext_t EXT_ODD  = 2'd2;

endpackage

// ===== design/cot_req_if.sv =====
// Request and response channels of the center-out tile order unit.
// Depends on cot_pkg.
interface cot_req_if;
  import cot_pkg::*;
  logic   valid;
  logic   ready;
  logic   kind;
  level_t zoom_level;
  coord_t row_first;
  coord_t row_limit;
  coord_t col_first;
  coord_t col_limit;
  modport source(output valid, kind, zoom_level, row_first, row_limit, col_first, col_limit,
                 input ready);
  modport sink(input valid, kind, zoom_level, row_first, row_limit, col_first, col_limit,
               output ready);
endinterface

interface cot_rsp_if;
  import cot_pkg::*;
  logic   valid;
  logic   ready;
  logic   tile_valid;
  level_t tile_level;
  coord_t tile_row;
  coord_t tile_col;
  logic   last_tile;
  logic   run_done;
  modport source(output valid, tile_valid, tile_level, tile_row, tile_col, last_tile, run_done,
                 input ready);
  modport sink(input valid, tile_valid, tile_level, tile_row, tile_col, last_tile, run_done,
               output ready);
endinterface

// ===== design/center_out_tile_order_unit.sv =====
// Center-out tile order unit: walks a row/column range in rings around its center.
// Depends on cot_pkg and the cot_req_if / cot_rsp_if channels.
//
// A start request latches a level and half-open row/column bounds; each next request
// during a run returns one tile, new to the current ring, in row-major order, and the run
// ends once a ring covers the whole range. Every request gives exactly one response. The
// unit takes one request per cycle while no skid entry is held: the walk state (current,
// previous and following ring windows plus the cursor) is updated in the cycle a request
// is accepted, and the response is registered. A skid register behind the output holds
// one more response during a response-side stall; ready is low while it is full.
module center_out_tile_order_unit (
  input logic       clk,
  input logic       rst,
  cot_req_if.sink   req,
  cot_rsp_if.source rsp
);
  import cot_pkg::*;

  typedef struct packed {
    coord_t lo;
    coord_t hi;
    logic   cov;
  } axis_t;

  typedef struct packed {
    coord_t r0;
    coord_t r1;
    coord_t c0;
    coord_t c1;
  } win_t;

  typedef struct packed {
    logic   found;
    coord_t row;
    coord_t col;
  } pos_t;

  typedef struct packed {
    logic   tile_valid;
    level_t tile_level;
    coord_t tile_row;
    coord_t tile_col;
    logic   last_tile;
    logic   run_done;
  } out_item_t;

  function automatic axis_t axis_window(coord_t s, ext_t e, coord_t b0, coord_t b1, coord_t k);
    logic [COORD_BITS+1:0] top;
    coord_t                gap;
    axis_t                 a;
    gap   = s - b0;
    top   = {2'b00, s} + {{COORD_BITS{1'b0}}, e} + {2'b00, k};
    a.lo  = (gap <= k) ? b0 : s - k;
    a.hi  = (top >= {2'b00, b1}) ? b1 : top[COORD_BITS-1:0];
    a.cov = (a.lo == b0) && (a.hi == b1);
    return a;
  endfunction

  function automatic win_t make_win(axis_t ar, axis_t ac);
    win_t w;
    w.r0 = ar.lo;
    w.r1 = ar.hi;
    w.c0 = ac.lo;
    w.c1 = ac.hi;
    return w;
  endfunction

  // first new tile of window w (previous window p) at the start of row nr or below
  function automatic pos_t row_start(coord_t nr, win_t w, win_t p);
    logic   old;
    logic   full;
    coord_t r;
    pos_t   q;
    old     = (nr >= p.r0) && (nr < p.r1);
    full    = (w.c0 >= p.c0) && (p.c1 >= w.c1);
    r       = (old && full) ? p.r1 : nr;
    q.row   = r;
    q.col   = (old && !full && w.c0 >= p.c0 && w.c0 < p.c1) ? p.c1 : w.c0;
    q.found = (r < w.r1);
    return q;
  endfunction

  logic      finished;
  level_t    level;
  coord_t    brow0, brow1, bcol0, bcol1;
  coord_t    srow, scol;
  ext_t      erow, ecol;
  coord_t    ring;
  win_t      cur, prv, nxt;
  logic      cov_r, cov_c, nxt_cov_r, nxt_cov_c;
  coord_t    cur_row, cur_col;

  logic      out_valid, skid_valid;
  out_item_t out_q, skid_q, item_next;
  logic      acc;

  logic [COORD_BITS:0] sum_r, sum_c;
  coord_t    s_new_r, s_new_c;
  ext_t      e_new_r, e_new_c;
  logic      empty;
  axis_t     w0r, w0c, w1r, w1c, wnr, wnc;
  coord_t    ring2;
  logic      old_row;
  coord_t    col_step, col_skip;
  logic      same_found;
  pos_t      pos_row, pos_ring;
  logic      more;

  assign req.ready = !skid_valid;
  assign acc       = req.valid && req.ready;

  always_comb begin
    sum_r   = {1'b0, req.row_first} + {1'b0, req.row_limit};
    sum_c   = {1'b0, req.col_first} + {1'b0, req.col_limit};
    s_new_r = sum_r[COORD_BITS:1];
    s_new_c = sum_c[COORD_BITS:1];
    e_new_r = (req.row_first[0] ^ req.row_limit[0]) ? EXT_ODD : EXT_EVEN;
    e_new_c = (req.col_first[0] ^ req.col_limit[0]) ? EXT_ODD : EXT_EVEN;
    empty   = (req.row_first >= req.row_limit) || (req.col_first >= req.col_limit);
    w0r     = axis_window(s_new_r, e_new_r, req.row_first, req.row_limit, '0);
    w0c     = axis_window(s_new_c, e_new_c, req.col_first, req.col_limit, '0);
    w1r     = axis_window(s_new_r, e_new_r, req.row_first, req.row_limit, coord_t'(1));
    w1c     = axis_window(s_new_c, e_new_c, req.col_first, req.col_limit, coord_t'(1));

    ring2   = ring + coord_t'(2);
    wnr     = axis_window(srow, erow, brow0, brow1, ring2);
    wnc     = axis_window(scol, ecol, bcol0, bcol1, ring2);

    old_row    = (cur_row >= prv.r0) && (cur_row < prv.r1);
    col_step   = cur_col + coord_t'(1);
    col_skip   = (old_row && col_step >= prv.c0 && col_step < prv.c1) ? prv.c1 : col_step;
    same_found = (col_skip < cur.c1);
    pos_row    = row_start(cur_row + coord_t'(1), cur, prv);
    pos_ring   = row_start(nxt.r0, nxt, cur);
    more       = same_found || pos_row.found || !(cov_r && cov_c);

    item_next = '0;
    if (req.kind == KIND_START) begin
      item_next.run_done = empty;
    end else if (finished) begin
      item_next.run_done = 1'b1;
    end else begin
      item_next.tile_valid = 1'b1;
      item_next.tile_level = level;
      item_next.tile_row   = cur_row;
      item_next.tile_col   = cur_col;
      item_next.last_tile  = !more;
      item_next.run_done   = !more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      finished   <= 1'b1;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (acc) begin
        if (req.kind == KIND_START) begin
          finished <= empty;
        end else if (!finished && !more) begin
          finished <= 1'b1;
        end
      end
      if (!out_valid || rsp.ready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= acc;
        end
      end else if (acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (req.kind == KIND_START) begin
        level <= req.zoom_level;
        brow0 <= req.row_first;
        brow1 <= req.row_limit;
        bcol0 <= req.col_first;
        bcol1 <= req.col_limit;
        if (!empty) begin
          srow      <= s_new_r;
          scol      <= s_new_c;
          erow      <= e_new_r;
          ecol      <= e_new_c;
          ring      <= '0;
          cur       <= make_win(w0r, w0c);
          nxt       <= make_win(w1r, w1c);
          prv       <= '0;
          cov_r     <= w0r.cov;
          cov_c     <= w0c.cov;
          nxt_cov_r <= w1r.cov;
          nxt_cov_c <= w1c.cov;
          cur_row   <= w0r.lo;
          cur_col   <= w0c.lo;
        end
      end else if (!finished) begin
        if (same_found) begin
          cur_col <= col_skip;
        end else if (pos_row.found) begin
          cur_row <= pos_row.row;
          cur_col <= pos_row.col;
        end else if (!(cov_r && cov_c)) begin
          ring      <= ring + coord_t'(1);
          prv       <= cur;
          cur       <= nxt;
          nxt       <= make_win(wnr, wnc);
          cov_r     <= nxt_cov_r;
          cov_c     <= nxt_cov_c;
          nxt_cov_r <= wnr.cov;
          nxt_cov_c <= wnc.cov;
          cur_row   <= pos_ring.row;
          cur_col   <= pos_ring.col;
        end
      end
    end
    if (!out_valid || rsp.ready) begin
      out_q <= skid_valid ? skid_q : item_next;
    end else if (acc) begin
      skid_q <= item_next;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.tile_valid = out_q.tile_valid;
  assign rsp.tile_level = out_q.tile_level;
  assign rsp.tile_row   = out_q.tile_row;
  assign rsp.tile_col   = out_q.tile_col;
  assign rsp.last_tile  = out_q.last_tile;
  assign rsp.run_done   = out_q.run_done;

endmodule

// ===== design/cot_checker.sv =====
// Port-level checks for the center-out tile order unit, bound to that unit.
// Depends on cot_pkg and center_out_tile_order_unit.
module cot_checker (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input logic            tile_valid,
  input cot_pkg::level_t tile_level,
  input cot_pkg::coord_t tile_row,
  input cot_pkg::coord_t tile_col,
  input logic            last_tile,
  input logic            run_done
);
  import cot_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && last_tile |-> tile_valid && run_done)
    else $error("last tile without tile or done");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !tile_valid |-> tile_row == '0 && tile_col == '0 && tile_level == '0
                                 && !last_tile)
    else $error("non-tile response carries data");

  a_done_only_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && tile_valid && !last_tile |-> !run_done)
    else $error("run done on a tile that is not last");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(tile_row) && $stable(tile_col))
    else $error("stalled response changed");

endmodule

bind center_out_tile_order_unit cot_checker u_cot_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .tile_valid (rsp.tile_valid),
  .tile_level (rsp.tile_level),
  .tile_row   (rsp.tile_row),
  .tile_col   (rsp.tile_col),
  .last_tile  (rsp.last_tile),
  .run_done   (rsp.run_done)
);
